// ===== sv/bankers_safety_checker_assert.svh =====
// Assertion macros shared by the banker's safety checker RTL.
`ifndef BANKERS_SAFETY_CHECKER_ASSERT_SVH
`define BANKERS_SAFETY_CHECKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bankers_safety_checker: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bankers_safety_checker: next-cycle check failed");

`endif

// ===== sv/bsc_pkg.sv =====
// Package of types, codes and defaults for the banker's safety checker.
package bsc_pkg;

  // Default parameter values.
  localparam int NUM_PROCESSES_DEF = 8;
  localparam int COUNT_BITS_DEF    = 8;

  // Command codes of the input request.
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_AVAIL = 2'd1;
  localparam logic [1:0] CMD_CHECK = 2'd2;
  localparam logic [1:0] CMD_REQ   = 2'd3;

  // Status codes of a result.
  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_SAFE     = 2'd1;
  localparam logic [1:0] ST_UNSAFE   = 2'd2;
  localparam logic [1:0] ST_INVALID  = 2'd3;

  // Input request payload.
  typedef struct packed {
    logic [1:0] command;
    logic [2:0] process_index;
    logic [7:0] count_a;
    logic [7:0] count_b;
    logic [7:0] count_c;
    logic [7:0] max_a;
    logic [7:0] max_b;
    logic [7:0] max_c;
  } in_t;

  // Result payload.
  typedef struct packed {
    logic [1:0] status;
    logic [2:0] sequence_process;
    logic       last;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       latch;
    logic       write_row;
    logic       write_avail;
    logic       init_check;
    logic       step_zero;
    logic       step_sweep;
    logic       emit_start;
    logic       emit_step;
    logic       one_load;
    logic [1:0] one_status;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] command;
    logic       load_ok;
    logic       req_ok;
    logic       idx_last;
    logic       sweep_again;
    logic       all_done;
    logic       emit_last;
    logic       out_free;
  } dp_sts_t;

endpackage

// ===== sv/bsc_dp.sv =====
// Datapath of the banker's safety checker: table, work vector, sequence and output register.
module bsc_dp #(
  parameter int NUM_PROCESSES = bsc_pkg::NUM_PROCESSES_DEF,
  parameter int COUNT_BITS    = bsc_pkg::COUNT_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  bsc_pkg::in_t    in_data,
  input  bsc_pkg::dp_cmd_t cmd,
  output bsc_pkg::dp_sts_t sts,
  input  logic            out_ready,
  output logic            out_valid,
  output bsc_pkg::out_t   out_data
);
  import bsc_pkg::*;

  localparam int KINDS = 3;
  localparam int CW    = COUNT_BITS;
  localparam int IW    = $clog2(NUM_PROCESSES);
  localparam int NW    = $clog2(NUM_PROCESSES + 1);
  localparam int WW    = COUNT_BITS + NW;
  localparam int XW    = (IW > 3) ? IW : 3;

  in_t              item_r;
  logic [CW-1:0]    alloc_r [NUM_PROCESSES][KINDS];
  logic [CW-1:0]    max_r   [NUM_PROCESSES][KINDS];
  logic [CW-1:0]    avail_r [KINDS];
  logic [WW-1:0]    work_r  [KINDS];
  logic [WW-1:0]    work_nxt [KINDS];
  logic [NUM_PROCESSES-1:0] fin_r, fin_nxt;
  logic [NW-1:0]    cnt_r, cnt_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic             granted_r, granted_nxt;
  logic [IW-1:0]    seq_r [NUM_PROCESSES];
  logic [IW-1:0]    emit_r, emit_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;

  logic [CW-1:0]    req_cnt [KINDS];
  logic [CW-1:0]    req_max [KINDS];
  logic [CW-1:0]    row_alloc [KINDS];
  logic [CW-1:0]    row_max [KINDS];
  logic [CW-1:0]    alloc_eff [KINDS];
  logic [CW-1:0]    need_raw [KINDS];
  logic [CW-1:0]    need_eff [KINDS];
  logic             pidx_ok, tentative, row_zero, row_fit, grant_now, finish_now;
  logic             load_ok, req_ok, idx_last, emit_last, out_free;

  // Counts of the held request, taken at the table width.
  assign req_cnt[0] = CW'(item_r.count_a);
  assign req_cnt[1] = CW'(item_r.count_b);
  assign req_cnt[2] = CW'(item_r.count_c);
  assign req_max[0] = CW'(item_r.max_a);
  assign req_max[1] = CW'(item_r.max_b);
  assign req_max[2] = CW'(item_r.max_c);

  // A request adds its amounts to the addressed row while the check runs.
  assign pidx_ok   = 32'(item_r.process_index) < NUM_PROCESSES;
  assign tentative = (item_r.command == CMD_REQ) &&
                     (XW'(item_r.process_index) == XW'(idx_r));
  assign idx_last  = idx_r == IW'(NUM_PROCESSES - 1);
  assign emit_last = emit_r == IW'(NUM_PROCESSES - 1);
  assign out_free  = !out_valid_r || out_ready;

  // Row read at the current index, its need, and the load and request checks.
  always_comb begin
    row_zero = 1'b1;
    row_fit  = 1'b1;
    load_ok  = pidx_ok;
    req_ok   = pidx_ok;
    for (int k = 0; k < KINDS; k++) begin
      row_alloc[k] = alloc_r[idx_r][k];
      row_max[k]   = max_r[idx_r][k];
      alloc_eff[k] = row_alloc[k] + (tentative ? req_cnt[k] : CW'(0));
      need_raw[k]  = row_max[k] - row_alloc[k];
      need_eff[k]  = row_max[k] - alloc_eff[k];
      if (need_eff[k] != CW'(0)) begin
        row_zero = 1'b0;
      end
      if (WW'(need_eff[k]) > work_r[k]) begin
        row_fit = 1'b0;
      end
      if (req_cnt[k] > req_max[k]) begin
        load_ok = 1'b0;
      end
      if (req_cnt[k] > need_raw[k] || req_cnt[k] > avail_r[k]) begin
        req_ok = 1'b0;
      end
    end
  end

  assign grant_now  = !fin_r[idx_r] && row_fit;
  assign finish_now = (cmd.step_zero && row_zero) || (cmd.step_sweep && grant_now);

  // Next state of the check: work vector, finish marks, count, index and grant flag.
  always_comb begin
    work_nxt    = work_r;
    fin_nxt     = fin_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    granted_nxt = granted_r;
    if (cmd.latch) begin
      idx_nxt = IW'(in_data.process_index);
    end
    if (cmd.init_check) begin
      for (int k = 0; k < KINDS; k++) begin
        work_nxt[k] = WW'(avail_r[k] - ((item_r.command == CMD_REQ) ? req_cnt[k] : CW'(0)));
      end
      fin_nxt     = '0;
      cnt_nxt     = '0;
      idx_nxt     = '0;
      granted_nxt = 1'b0;
    end
    if (finish_now) begin
      for (int k = 0; k < KINDS; k++) begin
        work_nxt[k] = work_r[k] + WW'(alloc_eff[k]);
      end
      fin_nxt[idx_r] = 1'b1;
      cnt_nxt        = cnt_r + NW'(1);
    end
    if (cmd.step_zero || cmd.step_sweep) begin
      idx_nxt = idx_last ? IW'(0) : idx_r + IW'(1);
    end
    if (cmd.step_sweep) begin
      granted_nxt = idx_last ? 1'b0 : (granted_r | grant_now);
    end
  end

  // Output register: single results and safe sequence entries.
  always_comb begin
    emit_nxt      = emit_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.emit_start) begin
      emit_nxt = '0;
    end
    if (cmd.one_load) begin
      out_valid_nxt                 = 1'b1;
      out_data_nxt.status           = cmd.one_status;
      out_data_nxt.sequence_process = 3'd0;
      out_data_nxt.last             = 1'b1;
    end
    if (cmd.emit_step) begin
      out_valid_nxt                 = 1'b1;
      out_data_nxt.status           = ST_SAFE;
      out_data_nxt.sequence_process = 3'(seq_r[emit_r]);
      out_data_nxt.last             = emit_last;
      emit_nxt                      = emit_r + IW'(1);
    end
  end

  // Control and table registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_PROCESSES; p++) begin
        for (int k = 0; k < KINDS; k++) begin
          alloc_r[p][k] <= '0;
          max_r[p][k]   <= '0;
        end
      end
      for (int k = 0; k < KINDS; k++) begin
        avail_r[k] <= '0;
        work_r[k]  <= '0;
      end
      fin_r       <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      granted_r   <= 1'b0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.write_row) begin
        for (int k = 0; k < KINDS; k++) begin
          alloc_r[IW'(item_r.process_index)][k] <= req_cnt[k];
          max_r[IW'(item_r.process_index)][k]   <= req_max[k];
        end
      end
      if (cmd.write_avail) begin
        for (int k = 0; k < KINDS; k++) begin
          avail_r[k] <= req_cnt[k];
        end
      end
      work_r      <= work_nxt;
      fin_r       <= fin_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      granted_r   <= granted_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_data;
    end
    if (finish_now) begin
      seq_r[cnt_r[IW-1:0]] <= idx_r;
    end
    out_data_r <= out_data_nxt;
  end

  assign sts.command     = item_r.command;
  assign sts.load_ok     = load_ok;
  assign sts.req_ok      = req_ok;
  assign sts.idx_last    = idx_last;
  assign sts.sweep_again = granted_r | grant_now;
  assign sts.all_done    = cnt_r == NW'(NUM_PROCESSES);
  assign sts.emit_last   = emit_last;
  assign sts.out_free    = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/bsc_ctrl.sv =====
// Controller state machine of the banker's safety checker.
module bsc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  bsc_pkg::dp_sts_t sts,
  output bsc_pkg::dp_cmd_t cmd
);
  import bsc_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SIMPLE = 4'd1;
  localparam logic [3:0] S_REQ    = 4'd2;
  localparam logic [3:0] S_INIT   = 4'd3;
  localparam logic [3:0] S_ZERO   = 4'd4;
  localparam logic [3:0] S_SWEEP  = 4'd5;
  localparam logic [3:0] S_DECIDE = 4'd6;
  localparam logic [3:0] S_ONE    = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [1:0] res_r, res_nxt;

  assign in_ready = state_r == S_IDLE;

  // Next state and datapath commands.
  always_comb begin
    state_nxt      = state_r;
    res_nxt        = res_r;
    cmd            = '0;
    cmd.one_status = res_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_SIMPLE;
        end
      end
      S_SIMPLE: begin
        case (sts.command)
          CMD_LOAD: begin
            cmd.write_row = sts.load_ok;
            res_nxt       = sts.load_ok ? ST_ACCEPTED : ST_INVALID;
            state_nxt     = S_ONE;
          end
          CMD_AVAIL: begin
            cmd.write_avail = 1'b1;
            res_nxt         = ST_ACCEPTED;
            state_nxt       = S_ONE;
          end
          CMD_CHECK: begin
            state_nxt = S_INIT;
          end
          default: begin
            state_nxt = S_REQ;
          end
        endcase
      end
      S_REQ: begin
        // Validate the request against the addressed row and available.
        if (sts.req_ok) begin
          state_nxt = S_INIT;
        end else begin
          res_nxt   = ST_INVALID;
          state_nxt = S_ONE;
        end
      end
      S_INIT: begin
        cmd.init_check = 1'b1;
        state_nxt      = S_ZERO;
      end
      S_ZERO: begin
        cmd.step_zero = 1'b1;
        if (sts.idx_last) begin
          state_nxt = S_SWEEP;
        end
      end
      S_SWEEP: begin
        // Repeat sweeps until one grants nothing.
        cmd.step_sweep = 1'b1;
        if (sts.idx_last && !sts.sweep_again) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.all_done) begin
          cmd.emit_start = 1'b1;
          state_nxt      = S_EMIT;
        end else begin
          res_nxt   = ST_UNSAFE;
          state_nxt = S_ONE;
        end
      end
      S_ONE: begin
        if (sts.out_free) begin
          cmd.one_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_step = 1'b1;
          if (sts.emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_r   <= ST_ACCEPTED;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

endmodule

// ===== sv/bankers_safety_checker.sv =====
// Top level of the banker's safety checker.
// Usage: in_valid/in_ready take one request of type in_t: load a process row,
// set the available vector, run the safety check, or try a request that is
// applied only for the duration of its check. Each request gives results on
// out_valid/out_ready as out_t items; the final one carries last. A safe check
// gives NUM_PROCESSES sequence entries, every other outcome a single status.
// Steps: load and set available each give one status. A check sets up the
// work vector, runs a zero-need pass over the process table, then repeats
// sweeps until one grants nothing, and then gives its entries, one entry a
// cycle while the receiver is ready; a request is first validated. Each pass
// visits one process row per cycle. One request is worked on at a time.
// Reset clears the table, available vector and check state.
// When the receiver stalls, the result register holds its item; the next
// request may still be accepted and runs until it has a result to deliver.
module bankers_safety_checker #(
  parameter int NUM_PROCESSES = bsc_pkg::NUM_PROCESSES_DEF,
  parameter int COUNT_BITS    = bsc_pkg::COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bsc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output bsc_pkg::out_t out_data
);
  import bsc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  bsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bsc_dp #(
    .NUM_PROCESSES (NUM_PROCESSES),
    .COUNT_BITS    (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  `include "bankers_safety_checker_assert.svh"

  // An accepted request keeps the block busy in the next cycle.
  `BSC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  // A result is loaded only when the output register can take it.
  `BSC_ASSERT_NOW(a_load_when_free, clk, rst_n, cmd.one_load || cmd.emit_step, sts.out_free)
  // A delivered sequence entry without last is followed at once by the next one.
  `BSC_ASSERT_NEXT(a_seq_unbroken, clk, rst_n, out_valid && out_ready && !out_data.last, out_valid)

endmodule
